// File: sv/cmwc_pkg.sv
package cmwc_pkg;

  localparam int unsigned LAG_DEPTH_DEF  = 4096;
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned RES_FIFO_DEPTH = 2;
  localparam int unsigned DIV_STEPS      = 32;
  localparam int unsigned CARRY_W        = 19;
  localparam int unsigned SEED_DIRECT    = 3;

  localparam logic [31:0]        GOLDEN_STEP     = 32'h9e3779b9;
  localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;
  localparam logic [14:0]        MULTIPLIER      = 15'd18705;
  localparam logic [31:0]        COMPLEMENT_BASE = 32'hfffffffe;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_RAW    = 2'd1,
    OP_RANGED = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_RANGED = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] seed;
    logic [31:0] low;
    logic [31:0] span;
  } cmd_t;

endpackage

// File: sv/cmwc_fifo.sv
module cmwc_fifo import cmwc_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = RES_FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/cmwc_front.sv
module cmwc_front import cmwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [31:0] seed_i,
  input  logic [31:0] low_i,
  input  logic [31:0] high_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o,
  input  logic        cmd_full_i
);

  logic  valid_q;
  cmd_t  cmd_q, cmd_d;
  logic  accept;
  logic [31:0] span;

  assign full       = valid_q && cmd_full_i;
  assign accept     = push && !full;
  assign cmd_push_o = valid_q;
  assign cmd_o      = cmd_q;
  assign span       = high_i - low_i + 32'd1;

  always_comb begin
    cmd_d.seed = seed_i;
    cmd_d.low  = low_i;
    cmd_d.span = span;
    unique case (op_e'(operation_i))
      OP_RESEED: cmd_d.kind = CMD_RESEED;
      OP_RAW:    cmd_d.kind = CMD_RAW;
      OP_RANGED: cmd_d.kind = (span == '0) ? CMD_RAW : CMD_RANGED;
      default:   cmd_d.kind = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!cmd_full_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// File: sv/cmwc_divider.sv
module cmwc_divider import cmwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  localparam int unsigned SW = $clog2(DIV_STEPS);

  logic          busy_q, done_q;
  logic [SW-1:0] cnt_q;
  logic [31:0]   dvd_q, div_q, rem_q;
  logic [32:0]   trial;
  logic [32:0]   nxt;

  assign trial  = {rem_q, dvd_q[31]};
  assign nxt    = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= nxt[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == SW'(DIV_STEPS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SW'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/cmwc_engine.sv
module cmwc_engine import cmwc_pkg::*; #(
  parameter int unsigned LAG_DEPTH = LAG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_empty_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output logic [31:0] res_o
);

  localparam int unsigned PW = $clog2(LAG_DEPTH);
  localparam int unsigned FW = $clog2(LAG_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_MULT   = 7'b0000100,
    S_WRITE  = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_SEED   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]        mem_q [LAG_DEPTH];
  logic [31:0]        rd_q;
  logic               hit_q;
  logic [PW-1:0]      pos_q, pos_next;
  logic [FW-1:0]      fill_q;
  logic [CARRY_W-1:0] carry_q;
  logic [46:0]        prod_q;
  logic [47:0]        t_sum;
  logic [31:0]        word;
  cmd_t               cur_q;
  logic [31:0]        res_q;
  logic [PW-1:0]      idx_q;
  logic [31:0]        acc_q, w1_q, w2_q, w3_q, seed_val;
  logic               wr_en;
  logic [PW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               take;
  logic               div_start, div_done;
  logic [31:0]        div_rem;

  assign take     = (state_q == S_IDLE) && !cmd_empty_i && !res_full_i;
  assign cmd_pop_o = take;
  assign res_push_o = (state_q == S_FINISH);
  assign res_o      = res_q;
  assign pos_next   = (pos_q == PW'(LAG_DEPTH - 1)) ? '0 : pos_q + 1'b1;
  assign t_sum      = {1'b0, prod_q} + 48'(carry_q);
  assign word       = COMPLEMENT_BASE - t_sum[31:0];
  assign seed_val   = (idx_q < PW'(SEED_DIRECT)) ? acc_q
                      : (w3_q ^ w2_q ^ GOLDEN_STEP ^ 32'(idx_q));
  assign div_start  = (state_q == S_WRITE) && (cur_q.kind == CMD_RANGED);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = word;
    if (state_q == S_SEED) begin
      wr_en   = 1'b1;
      wr_addr = idx_q;
      wr_data = seed_val;
    end else if (state_q == S_WRITE) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          unique case (cmd_i.kind) inside
            CMD_RESEED:          state_d = S_SEED;
            CMD_RAW, CMD_RANGED: state_d = S_READ;
            default:             state_d = S_FINISH;
          endcase
        end
      end
      S_READ:  state_d = S_MULT;
      S_MULT:  state_d = S_WRITE;
      S_WRITE: state_d = (cur_q.kind == CMD_RANGED) ? S_DIV : S_FINISH;
      S_DIV:   state_d = div_done ? S_FINISH : S_DIV;
      S_FINISH: state_d = S_IDLE;
      S_SEED:  state_d = (idx_q == PW'(LAG_DEPTH - 1)) ? S_FINISH : S_SEED;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q  <= mem_q[pos_q];
    hit_q <= (FW'(pos_q) < fill_q);
    prod_q <= MULTIPLIER * (hit_q ? rd_q : 32'd0);
    if (take) begin
      cur_q <= cmd_i;
      acc_q <= cmd_i.seed;
      idx_q <= '0;
      res_q <= '0;
    end
    if (state_q == S_SEED) begin
      acc_q <= acc_q + GOLDEN_STEP;
      w1_q  <= seed_val;
      w2_q  <= w1_q;
      w3_q  <= w2_q;
      idx_q <= idx_q + 1'b1;
    end
    if (state_q == S_WRITE) begin
      res_q <= word;
    end
    if (state_q == S_DIV && div_done) begin
      res_q <= div_rem + cur_q.low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= PW'(LAG_DEPTH - 1);
      fill_q  <= '0;
      carry_q <= CARRY_RESET;
    end else begin
      state_q <= state_d;
      if (take && (cmd_i.kind == CMD_RAW || cmd_i.kind == CMD_RANGED)) begin
        pos_q <= pos_next;
      end
      if (state_q == S_WRITE) begin
        carry_q <= CARRY_W'(t_sum[47:32]);
        if (FW'(pos_q) == fill_q) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (state_q == S_SEED && idx_q == PW'(LAG_DEPTH - 1)) begin
        fill_q <= FW'(LAG_DEPTH);
      end
    end
  end

  cmwc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (word),
    .divisor_i  (cur_q.span),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

endmodule

// File: sv/cmwc_random_generator.sv
// Engine steps: a raw draw reads the lag store, multiplies, writes the new word back and
// finishes; a ranged draw then runs a 32-step restoring modulo before it finishes. The engine
// holds one item at a time; a reseed makes one lag store write per cycle.
// Reset: asynchronous, active low; carry 362436, position LAG_DEPTH - 1, queues empty.
// The lag store reads as zero past a fill count after reset; no clearing pass.
module cmwc_random_generator import cmwc_pkg::*; #(
  parameter int unsigned LAG_DEPTH = LAG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [31:0] seed_i,
  input  logic signed [31:0] low_bound_i,
  input  logic signed [31:0] high_bound_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value_o
);

  cmd_t        front_cmd, back_cmd;
  logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic        res_push, res_full;
  logic [31:0] res_data;

  cmwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .seed_i      (seed_i),
    .low_i       (low_bound_i),
    .high_i      (high_bound_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd),
    .cmd_full_i  (cmd_full)
  );

  cmwc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (back_cmd),
    .empty_o (cmd_empty)
  );

  cmwc_engine #(
    .LAG_DEPTH (LAG_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_data)
  );

  cmwc_fifo #(
    .WIDTH (32),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (value_o),
    .empty_o (empty)
  );

endmodule
